FILE: hdl/rrta_pkg.sv
// Shared types, constants and register indexes for the round robin task assigner.
package rrta_pkg;

  localparam int MAX_STAGES_DEF  = 16;
  localparam int MAX_WORKERS_DEF = 255;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_STAGE_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PARALLEL_MASK = 1'b1;

  localparam logic [4:0]  STAGE_COUNT_RST   = 5'd16;
  localparam logic [15:0] PARALLEL_MASK_RST = 16'h0000;

  localparam logic [1:0] OP_REQUEST = 2'd0;
  localparam logic [1:0] OP_RETURN  = 2'd1;
  localparam logic [1:0] OP_FINISH  = 2'd2;

  typedef struct packed {
    logic [1:0] operation;
    logic       has_returned;
    logic [3:0] returned_stage;
    logic [3:0] finished_stage;
  } req_t;

  typedef struct packed {
    logic       grant_valid;
    logic [3:0] grant_stage;
    logic       deactivate_valid;
    logic [3:0] deactivate_stage;
  } rsp_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

FILE: hdl/rrta_stage_mem.sv
// Per-stage state memory: finished flag and worker count, registered read, write-first.
module rrta_stage_mem #(
  parameter int MAX_STAGES  = rrta_pkg::MAX_STAGES_DEF,
  parameter int MAX_WORKERS = rrta_pkg::MAX_WORKERS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  rrta_pkg::mem_ctl_t                   ctl,
  input  logic [$clog2(MAX_STAGES)-1:0]        raddr,
  input  logic [$clog2(MAX_STAGES)-1:0]        waddr,
  input  logic [$clog2(MAX_WORKERS+1):0]       wdata,
  output logic [$clog2(MAX_WORKERS+1):0]       rd_data
);

  localparam int DW = $clog2(MAX_WORKERS + 1) + 1;

  logic [DW-1:0]   mem [MAX_STAGES];
  logic            entry_valid [MAX_STAGES];

  // Entries never written since reset read as zero through their valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_STAGES; i++) begin
        entry_valid[i] <= 1'b0;
      end
    end else if (ctl.wr_en) begin
      entry_valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (ctl.rd_en) begin
      if (ctl.wr_en && (waddr == raddr)) begin
        rd_data <= wdata;
      end else if (entry_valid[raddr]) begin
        rd_data <= mem[raddr];
      end else begin
        rd_data <= '0;
      end
    end
  end

endmodule

FILE: hdl/rrta_ctrl.sv
// Sequencer: return and finish handling, pipelined round robin scan and result register.
module rrta_ctrl #(
  parameter int MAX_STAGES  = rrta_pkg::MAX_STAGES_DEF,
  parameter int MAX_WORKERS = rrta_pkg::MAX_WORKERS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [4:0]                           stages_used,
  input  logic [15:0]                          parallel_mask,
  input  logic                                 req_valid,
  output logic                                 req_ready,
  input  rrta_pkg::req_t                       req,
  output logic                                 rsp_valid,
  input  logic                                 rsp_ready,
  output rrta_pkg::rsp_t                       rsp,
  output rrta_pkg::mem_ctl_t                   mem_ctl,
  output logic [$clog2(MAX_STAGES)-1:0]        raddr,
  output logic [$clog2(MAX_STAGES)-1:0]        waddr,
  output logic [$clog2(MAX_WORKERS+1):0]       wdata,
  input  logic [$clog2(MAX_WORKERS+1):0]       rd_data
);

  localparam int AW = $clog2(MAX_STAGES);
  localparam int CW = $clog2(MAX_WORKERS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RET  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]    state;
  logic [2:0]    state_next;
  logic [4:0]    scan_ptr;
  logic [1:0]    op_q;
  logic [3:0]    rs_q;
  logic [3:0]    fs_q;
  logic [4:0]    iss_s;
  logic [4:0]    iss_cnt;
  logic [4:0]    chk_s;
  logic          chk_v;
  logic          chk_last;
  logic          gv;
  logic [3:0]    gs;
  logic          dv;
  logic [3:0]    ds;

  logic          rd_fin;
  logic [CW-1:0] rd_cnt;
  logic [CW-1:0] cnt_inc;
  logic          chk_par;
  logic          eligible;
  logic          ret_ok_in;
  logic          fin_ok_in;
  logic          issue;
  logic          out_free;
  logic [4:0]    scan_start;

  function automatic logic [4:0] next_stage(input logic [4:0] s, input logic [4:0] n);
    logic [5:0] sum;
    begin
      sum = {1'b0, s} + 6'd1;
      return (sum == {1'b0, n}) ? 5'd0 : sum[4:0];
    end
  endfunction

  assign req_ready  = (state == S_IDLE);
  assign rd_fin     = rd_data[CW];
  assign rd_cnt     = rd_data[CW-1:0];
  assign cnt_inc    = (rd_cnt < CW'(MAX_WORKERS)) ? rd_cnt + CW'(1) : rd_cnt;
  assign chk_par    = !chk_s[4] && parallel_mask[chk_s[3:0]];
  assign eligible   = !rd_fin && (chk_par || (rd_cnt == '0));
  assign ret_ok_in  = req.has_returned && ({1'b0, req.returned_stage} < stages_used);
  assign fin_ok_in  = {1'b0, req.finished_stage} < stages_used;
  assign issue      = (iss_cnt != stages_used);
  assign out_free   = !rsp_valid || rsp_ready;
  assign scan_start = (scan_ptr < stages_used) ? scan_ptr : 5'd0;

  always_comb begin
    mem_ctl    = '0;
    raddr      = '0;
    waddr      = '0;
    wdata      = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          case (req.operation)
            rrta_pkg::OP_REQUEST, rrta_pkg::OP_RETURN: begin
              if (ret_ok_in) begin
                mem_ctl.rd_en = 1'b1;
                raddr         = AW'(req.returned_stage);
                state_next    = S_RET;
              end else if (req.operation == rrta_pkg::OP_REQUEST) begin
                state_next = S_SCAN;
              end else begin
                state_next = S_DONE;
              end
            end
            rrta_pkg::OP_FINISH: begin
              if (fin_ok_in) begin
                mem_ctl.rd_en = 1'b1;
                raddr         = AW'(req.finished_stage);
                state_next    = S_FIN;
              end else begin
                state_next = S_DONE;
              end
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_RET: begin
        if (rd_cnt != '0) begin
          mem_ctl.wr_en = 1'b1;
          waddr         = AW'(rs_q);
          wdata         = {rd_fin, rd_cnt - CW'(1)};
        end
        state_next = (op_q == rrta_pkg::OP_REQUEST) ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        // One read is issued per cycle while the previous stage is checked.
        if (issue) begin
          mem_ctl.rd_en = 1'b1;
          raddr         = AW'(iss_s);
        end
        if (chk_v && eligible) begin
          mem_ctl.wr_en = 1'b1;
          waddr         = AW'(chk_s);
          wdata         = {1'b0, cnt_inc};
          state_next    = S_DONE;
        end else if (chk_v && chk_last) begin
          state_next = S_DONE;
        end
      end
      S_FIN: begin
        mem_ctl.wr_en = 1'b1;
        waddr         = AW'(fs_q);
        wdata         = {1'b1, rd_cnt};
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      scan_ptr  <= 5'd0;
      rsp_valid <= 1'b0;
      chk_v     <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == S_DONE) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op_q    <= req.operation;
            rs_q    <= req.returned_stage;
            fs_q    <= req.finished_stage;
            gv      <= 1'b0;
            gs      <= 4'd0;
            dv      <= 1'b0;
            ds      <= 4'd0;
            iss_s   <= scan_start;
            iss_cnt <= 5'd0;
            chk_v   <= 1'b0;
          end
        end
        S_RET: begin
          if ((op_q == rrta_pkg::OP_REQUEST) && (rd_cnt == CW'(1)) && rd_fin) begin
            dv <= 1'b1;
            ds <= rs_q;
          end
        end
        S_SCAN: begin
          if (issue) begin
            iss_s    <= next_stage(iss_s, stages_used);
            iss_cnt  <= iss_cnt + 5'd1;
            chk_s    <= iss_s;
            chk_last <= ((iss_cnt + 5'd1) == stages_used);
            chk_v    <= 1'b1;
          end else begin
            chk_v <= 1'b0;
          end
          if (chk_v && eligible) begin
            gv       <= 1'b1;
            gs       <= chk_s[3:0];
            scan_ptr <= next_stage(chk_s, stages_used);
          end
        end
        S_DONE: begin
          if (out_free) begin
            rsp.grant_valid      <= gv;
            rsp.grant_stage      <= gs;
            rsp.deactivate_valid <= dv;
            rsp.deactivate_stage <= ds;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/round_robin_task_assigner_core.sv
// Top level: configuration registers, stage memory and sequencer of the task assigner.
// Flow: a request with a return first reads the returned stage and takes a worker off it,
// then scans the stages in use for a grant; a return or finish reads its stage and updates
// it; an ignored item (unused operation, stage out of range, no worker back) skips memory.
// One item at a time: a new beat is taken only once the last result is registered, and the
// scan reads one memory entry per cycle through the single read port.
// Reset: synchronous, clears the scan pointer, handshake state and the memory valid bits
// at once (no clearing pass); registers return to sixteen stages and no parallel stages.
module round_robin_task_assigner_core #(
  parameter int MAX_STAGES  = rrta_pkg::MAX_STAGES_DEF,
  parameter int MAX_WORKERS = rrta_pkg::MAX_WORKERS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rrta_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rrta_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  rrta_pkg::req_t                    req,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output rrta_pkg::rsp_t                    rsp
);

  localparam int AW = $clog2(MAX_STAGES);
  localparam int DW = $clog2(MAX_WORKERS + 1) + 1;

  logic [4:0]         stage_count;
  logic [15:0]        parallel_mask;
  logic [4:0]         stages_used;
  rrta_pkg::mem_ctl_t mem_ctl;
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;
  logic [DW-1:0]      wdata;
  logic [DW-1:0]      rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_count   <= rrta_pkg::STAGE_COUNT_RST;
      parallel_mask <= rrta_pkg::PARALLEL_MASK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rrta_pkg::CFG_STAGE_COUNT:   stage_count   <= cfg_data[4:0];
        rrta_pkg::CFG_PARALLEL_MASK: parallel_mask <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // A stage count of zero means one stage; anything above the memory depth is clipped.
  always_comb begin
    if (stage_count == 5'd0) begin
      stages_used = 5'd1;
    end else if (32'(stage_count) > MAX_STAGES) begin
      stages_used = 5'(MAX_STAGES);
    end else begin
      stages_used = stage_count;
    end
  end

  rrta_ctrl #(
    .MAX_STAGES  (MAX_STAGES),
    .MAX_WORKERS (MAX_WORKERS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .stages_used   (stages_used),
    .parallel_mask (parallel_mask),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .req           (req),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .rsp           (rsp),
    .mem_ctl       (mem_ctl),
    .raddr         (raddr),
    .waddr         (waddr),
    .wdata         (wdata),
    .rd_data       (rd_data)
  );

  rrta_stage_mem #(
    .MAX_STAGES  (MAX_STAGES),
    .MAX_WORKERS (MAX_WORKERS)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mem_ctl),
    .raddr   (raddr),
    .waddr   (waddr),
    .wdata   (wdata),
    .rd_data (rd_data)
  );

endmodule

FILE: hdl/rrta_checker.sv
// Port-level checks on the task assigner, bound to the top level.
module rrta_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input rrta_pkg::rsp_t rsp
);

  // A result beat that is not taken stays on the port unchanged.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result beat dropped or changed while stalled");

  a_grant_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.grant_valid |-> (rsp.grant_stage == 4'd0))
    else $error("grant stage set without a grant");

  a_deact_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.deactivate_valid |-> (rsp.deactivate_stage == 4'd0))
    else $error("deactivation stage set without an event");

  // No result beat is raised in the cycle right after a beat is taken.
  a_no_early_rsp: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !rsp_valid || $past(rsp_valid))
    else $error("result appeared in the cycle after a beat was taken");

endmodule

bind round_robin_task_assigner_core rrta_checker u_rrta_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
